// File: design/dltr_pkg.sv
// dltr_pkg: types, constants and controller codes for the dda line tile rasterizer
// used by every module of the block
// no dependencies
`default_nettype none

package dltr_pkg;

	localparam int COORD_W           = 16;
	localparam int COLS_W            = 7;
	localparam int TILE_SHIFT        = 3;
	localparam int MAX_PIXELS_DEF    = 64;
	localparam int FRACTION_BITS_DEF = 13;
	localparam int PROD_W            = COLS_W + COORD_W - TILE_SHIFT;

	localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(48);

	typedef logic [COLS_W-1:0] cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_parallax;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_parallax;
	} line_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COORD_W-1:0] tile_index;
		logic               truncated;
		logic               last;
	} pixel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_ORDER,
		ST_MINOR_GO,
		ST_MINOR_WAIT,
		ST_PAR_GO,
		ST_PAR_WAIT,
		ST_STEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic delta;
		logic order;
		logic div_start;
		logic div_par;
		logic take_minor;
		logic take_par;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic zero_len;
		logic div_done;
		logic out_free;
		logic last_pix;
	} status_t;

endpackage

`default_nettype wire

// File: design/dltr_stream_if.sv
// dltr_stream_if: valid/ready channel carrying one payload type
// payload types come from dltr_pkg
`default_nettype none

interface dltr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/dltr_div.sv
// dltr_div: restoring divider, one quotient bit per cycle
// unsigned dividend of W bits over a 16-bit divisor; uses dltr_pkg widths
`default_nettype none

module dltr_div #(
	parameter int W = dltr_pkg::FRACTION_BITS_DEF + dltr_pkg::COORD_W
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [W-1:0]                 dividend,
	input  wire logic [dltr_pkg::COORD_W-1:0] divisor,
	output logic      [W-1:0]                 quotient,
	output logic                              done
);
	localparam int CNT_W = $clog2(W + 1);
	localparam int DW    = dltr_pkg::COORD_W;

	logic [W-1:0]     quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic             ge;
	logic [DW-1:0]    rem_nx;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? DW'(rem_sh - {1'b0, div_q}) : rem_sh[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: design/dltr_ctrl.sv
// dltr_ctrl: sequencer for one line: setup, two divisions, pixel walk
// drives dltr_pkg::cmd_t, reads dltr_pkg::status_t
`default_nettype none

module dltr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              line_valid,
	output logic                   line_ready,
	input  wire dltr_pkg::status_t status,
	output dltr_pkg::cmd_t         cmd
);
	dltr_pkg::state_t state_q;
	dltr_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dltr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		line_ready = 1'b0;
		unique case (state_q)
			dltr_pkg::ST_IDLE: begin
				line_ready = 1'b1;
				if (line_valid) begin
					cmd.load = 1'b1;
					state_nx = dltr_pkg::ST_DELTA;
				end
			end
			dltr_pkg::ST_DELTA: begin
				cmd.delta = 1'b1;
				state_nx  = dltr_pkg::ST_ORDER;
			end
			dltr_pkg::ST_ORDER: begin
				cmd.order = 1'b1;
				// both endpoints on the same pixel: no output at all
				state_nx  = status.zero_len ? dltr_pkg::ST_IDLE : dltr_pkg::ST_MINOR_GO;
			end
			dltr_pkg::ST_MINOR_GO: begin
				cmd.div_start = 1'b1;
				state_nx      = dltr_pkg::ST_MINOR_WAIT;
			end
			dltr_pkg::ST_MINOR_WAIT: begin
				if (status.div_done) begin
					cmd.take_minor = 1'b1;
					state_nx       = dltr_pkg::ST_PAR_GO;
				end
			end
			dltr_pkg::ST_PAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_par   = 1'b1;
				state_nx      = dltr_pkg::ST_PAR_WAIT;
			end
			dltr_pkg::ST_PAR_WAIT: begin
				cmd.div_par = 1'b1;
				if (status.div_done) begin
					cmd.take_par = 1'b1;
					state_nx     = dltr_pkg::ST_STEP;
				end
			end
			dltr_pkg::ST_STEP: begin
				cmd.step = 1'b1;
				state_nx = dltr_pkg::ST_EMIT;
			end
			dltr_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last_pix) begin
						state_nx = dltr_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = dltr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/dltr_dp.sv
// dltr_dp: line setup, fixed-point step registers, walk accumulators, output register
// uses dltr_pkg types and dltr_div for the two step quotients
`default_nettype none

module dltr_dp #(
	parameter int MAX_PIXELS    = dltr_pkg::MAX_PIXELS_DEF,
	parameter int FRACTION_BITS = dltr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dltr_pkg::line_t   line,
	input  wire logic              cfg_we,
	input  wire dltr_pkg::cfg_t    cfg_data,
	input  wire dltr_pkg::cmd_t    cmd,
	output dltr_pkg::status_t      status,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output dltr_pkg::pixel_t       pixel
);
	localparam int CW = dltr_pkg::COORD_W;
	localparam int W  = FRACTION_BITS + CW;
	localparam int IW = $clog2(MAX_PIXELS);
	localparam int TS = dltr_pkg::TILE_SHIFT;
	localparam int PW = dltr_pkg::PROD_W;
	localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

	dltr_pkg::line_t line_q;
	dltr_pkg::cfg_t  columns_q;

	logic [CW:0]   ddx_q, ddy_q, ddp_q;
	logic [CW-1:0] adp_q, bdp_q;

	logic          xmajor_q, mneg_q, pneg_q, cut_q;
	logic [CW-1:0] major_q, minor_q, pmag_q;
	logic [IW-1:0] last_idx_q, pix_q;

	logic [W-1:0] y_q, d_q;
	logic [W-1:0] step_x_q, step_y_q, par_step_q, step_d_q;

	logic         out_valid_q;
	dltr_pkg::pixel_t pixel_q;

	logic [CW-1:0] adx, ady, apm, major, sy, sd;
	logic          xmaj, swap, dx_pos, dy_pos, dp_pos, cut;
	logic [W-1:0]  dividend, quotient, q_signed;
	logic          div_done;
	logic [CW-1:0] px, py;
	logic [PW-1:0] prod;

	// register the request and the signed differences
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q <= line;
		end
		if (cmd.delta) begin
			ddx_q <= {line_q.end_x[CW-1], line_q.end_x} - {line_q.start_x[CW-1], line_q.start_x};
			ddy_q <= {line_q.end_y[CW-1], line_q.end_y} - {line_q.start_y[CW-1], line_q.start_y};
			ddp_q <= {line_q.end_parallax[CW-1], line_q.end_parallax}
				- {line_q.start_parallax[CW-1], line_q.start_parallax};
			adp_q <= line_q.start_x - line_q.start_parallax;
			bdp_q <= line_q.end_x - line_q.end_parallax;
		end
	end

	assign adx    = ddx_q[CW] ? CW'(-ddx_q) : ddx_q[CW-1:0];
	assign ady    = ddy_q[CW] ? CW'(-ddy_q) : ddy_q[CW-1:0];
	assign apm    = ddp_q[CW] ? CW'(-ddp_q) : ddp_q[CW-1:0];
	assign dx_pos = !ddx_q[CW] && (ddx_q != '0);
	assign dy_pos = !ddy_q[CW] && (ddy_q != '0);
	assign dp_pos = !ddp_q[CW] && (ddp_q != '0);
	assign xmaj   = ady <= adx;
	// walk always runs toward the larger major coordinate
	assign swap   = xmaj ? ddx_q[CW] : ddy_q[CW];
	assign major  = xmaj ? adx : ady;
	assign cut    = major >= CW'(MAX_PIXELS);
	assign sy     = swap ? line_q.end_y : line_q.start_y;
	assign sd     = swap ? bdp_q : adp_q;

	always_ff @(posedge clk) begin
		if (cmd.order) begin
			xmajor_q   <= xmaj;
			major_q    <= major;
			minor_q    <= xmaj ? ady : adx;
			pmag_q     <= apm;
			pneg_q     <= swap ? dp_pos : ddp_q[CW];
			mneg_q     <= xmaj ? (swap ? dy_pos : ddy_q[CW]) : (swap ? dx_pos : ddx_q[CW]);
			cut_q      <= cut;
			last_idx_q <= cut ? IW'(MAX_PIXELS - 1) : major[IW-1:0];
		end
	end

	assign dividend = {(cmd.div_par ? pmag_q : minor_q), {FRACTION_BITS{1'b0}}};

	dltr_div #(
		.W (W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (major_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// quotient truncates toward zero, sign applied afterwards
	assign q_signed = (cmd.take_par ? pneg_q : mneg_q) ? (~quotient + W'(1)) : quotient;

	always_ff @(posedge clk) begin
		if (cmd.take_minor) begin
			step_x_q <= xmajor_q ? ONE : q_signed;
			step_y_q <= xmajor_q ? q_signed : ONE;
		end
		if (cmd.take_par) begin
			par_step_q <= q_signed;
		end
		if (cmd.step) begin
			// x and parallax only ever appear as their difference
			step_d_q <= step_x_q - par_step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.order) begin
			y_q   <= {sy, {FRACTION_BITS{1'b0}}};
			d_q   <= {sd, {FRACTION_BITS{1'b0}}};
			pix_q <= '0;
		end else if (cmd.emit) begin
			y_q   <= y_q + step_y_q;
			d_q   <= d_q + step_d_q;
			pix_q <= pix_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= dltr_pkg::COLS_RESET;
		end else if (cfg_we) begin
			columns_q <= cfg_data;
		end
	end

	assign px   = d_q[FRACTION_BITS +: CW];
	assign py   = y_q[FRACTION_BITS +: CW];
	assign prod = PW'(columns_q) * PW'(py >> TS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_q.pixel_x    <= px;
			pixel_q.pixel_y    <= py;
			pixel_q.tile_index <= CW'(prod) + CW'(px >> TS);
			pixel_q.truncated  <= cut_q;
			pixel_q.last       <= pix_q == last_idx_q;
		end
	end

	assign status.zero_len = (ddx_q == '0) && (ddy_q == '0);
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.last_pix = pix_q == last_idx_q;

	assign out_valid = out_valid_q;
	assign pixel     = pixel_q;

endmodule

`default_nettype wire

// File: design/dda_line_tile_rasterizer.sv
// dda line tile rasterizer: one line request in, one pixel request per walked pixel out.
// after the line is taken, the first pixel follows two setup states, two serial divisions
// of FRACTION_BITS+16 quotient bits with a start and a take step each, a step state and
// the first emit; then one pixel per cycle while the output is taken, at most MAX_PIXELS;
// next line taken right after the last emit, and a zero-length line gives no pixels.
// arst_n clears sequencer, output valid, divider; columns 48.
`default_nettype none

module dda_line_tile_rasterizer #(
	parameter int MAX_PIXELS    = dltr_pkg::MAX_PIXELS_DEF,
	parameter int FRACTION_BITS = dltr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dltr_stream_if.sink    line_in,
	dltr_stream_if.sink    cfg,
	dltr_stream_if.source  pixel_out
);
	dltr_pkg::cmd_t    cmd;
	dltr_pkg::status_t status;
	dltr_pkg::pixel_t  pixel;
	logic              line_ready;
	logic              out_valid;

	// register writes are always taken
	assign cfg.ready      = 1'b1;
	assign line_in.ready  = line_ready;
	assign pixel_out.valid = out_valid;
	assign pixel_out.data  = pixel;

	dltr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_in.valid),
		.line_ready (line_ready),
		.status     (status),
		.cmd        (cmd)
	);

	dltr_dp #(
		.MAX_PIXELS    (MAX_PIXELS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.line      (line_in.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (pixel_out.ready),
		.out_valid (out_valid),
		.pixel     (pixel)
	);

endmodule

`default_nettype wire
